// ===== rtl/button_click_classifier_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Button click classifier - assertion macros
// Shared concurrent assertion forms for the classifier checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_UNIT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high
`define BCC_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included
`define BCC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier package
// Phase and click codes, register indexes, reset values and word widths.
// ----------------------------------------------------------------------------
package bcc_pkg;

   // Word widths on the stream and register ports
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 8;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 8;
   localparam int THRESH_WIDTH   = 8;

   // Default elapsed-tick counter width
   localparam int TICK_COUNT_WIDTH = 8;

   // Register reset values
   localparam logic [THRESH_WIDTH-1:0] DEBOUNCE_RESET = 8'd3;
   localparam logic [THRESH_WIDTH-1:0] LONG_PRESS_RESET = 8'd100;
   localparam logic [THRESH_WIDTH-1:0] DOUBLE_WINDOW_RESET = 8'd50;

   typedef enum logic [2:0] {
      PHASE_IDLE     = 3'd0,
      PHASE_DEBOUNCE = 3'd1,
      PHASE_HELD     = 3'd2,
      PHASE_WAIT     = 3'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_SHORT  = 2'd1,
      KIND_LONG   = 2'd2,
      KIND_DOUBLE = 2'd3
   } kind_type;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_DEBOUNCE      = 2'd0,
      CSR_LONG_PRESS    = 2'd1,
      CSR_DOUBLE_WINDOW = 2'd2
   } csr_index_type;

endpackage

// ===== rtl/button_click_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier
// Debounces a sampled button level and reports short, long and double clicks.
// ----------------------------------------------------------------------------
// Each request word carries one button sample (pressed, tick) and produces
// exactly one response word holding a click code (none, short, long, double).
// A word is taken every clock cycle while the response register is empty or
// being drained, so throughput is one word per cycle and the response appears
// in the cycle after its request is taken. The rate is set by the single
// phase/counter update, which is a few compares and a counter increment. The
// elapsed counter counts ticks, saturates, and restarts on every phase change.
// The user must write the three 8-bit csr thresholds while idle (not enforced).
// ----------------------------------------------------------------------------
module button_click_classifier_unit #(
   parameter int TickCountWidth = bcc_pkg::TICK_COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [0] pressed, [1] tick, [7:2] zero
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bcc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // rsp_tdata: [1:0] click_kind, [7:2] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bcc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                csr_we,
   input  logic [bcc_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [bcc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import bcc_pkg::*;

   localparam int CmpWidth = (TickCountWidth > THRESH_WIDTH) ? TickCountWidth : THRESH_WIDTH;
   localparam logic [TickCountWidth-1:0] ElapsedMax = {TickCountWidth{1'b1}};

   logic [THRESH_WIDTH-1:0]   debounce_ff;
   logic [THRESH_WIDTH-1:0]   long_press_ff;
   logic [THRESH_WIDTH-1:0]   double_window_ff;

   phase_type                 phase_ff, phase_in;
   logic [TickCountWidth-1:0] elapsed_ff, elapsed_in;
   logic                      second_ff, second_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   kind_type                  kind_ff, kind_in;

   logic                      accept;
   logic                      pressed;
   logic                      tick;
   logic [CmpWidth-1:0]       elapsed_wide;
   logic                      debounce_done;
   logic                      long_reached;
   logic                      window_done;

   assign pressed = req_tdata[0];
   assign tick    = req_tdata[1];

   // Take a word whenever the response register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Compare at a common width: thresholds beyond the counter are never met
   assign elapsed_wide  = CmpWidth'(elapsed_ff);
   assign debounce_done = elapsed_wide >= CmpWidth'(debounce_ff);
   assign long_reached  = elapsed_wide >= CmpWidth'(long_press_ff);
   assign window_done   = elapsed_wide >= CmpWidth'(double_window_ff);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PHASE_DEBOUNCE: begin
            if (debounce_done) begin
               phase_in = pressed ? PHASE_HELD : PHASE_IDLE;
            end
         end
         PHASE_HELD: begin
            if (!pressed) begin
               if (long_reached || second_ff) begin
                  phase_in = PHASE_IDLE;
               end else begin
                  phase_in = PHASE_WAIT;
               end
            end
         end
         PHASE_WAIT: begin
            if (window_done) begin
               phase_in = PHASE_IDLE;
            end else if (pressed) begin
               phase_in = PHASE_DEBOUNCE;
            end
         end
         default: begin
            if (pressed) begin
               phase_in = PHASE_DEBOUNCE;
            end
         end
      endcase
   end

   // Click code and second-press mark
   always_comb begin
      kind_in   = KIND_NONE;
      second_in = second_ff;
      case (phase_ff)
         PHASE_HELD: begin
            if (!pressed) begin
               if (long_reached) begin
                  kind_in = KIND_LONG;
               end else if (second_ff) begin
                  kind_in = KIND_DOUBLE;
               end
            end
         end
         PHASE_WAIT: begin
            if (window_done) begin
               kind_in = KIND_SHORT;
            end else if (pressed) begin
               second_in = 1'b1;
            end
         end
         default: begin
            kind_in = KIND_NONE;
         end
      endcase
      // Drop the mark on every return to idle
      if (phase_in == PHASE_IDLE) begin
         second_in = 1'b0;
      end
   end

   // Restart the counter on a phase change, else count ticks and saturate
   always_comb begin
      elapsed_in = elapsed_ff;
      if (phase_in != phase_ff) begin
         elapsed_in = '0;
      end else if (tick && (elapsed_ff != ElapsedMax)) begin
         elapsed_in = elapsed_ff + TickCountWidth'(1);
      end
   end

   // Hold the response word until it is taken
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         elapsed_ff   <= '0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff   <= phase_in;
            elapsed_ff <= elapsed_in;
            second_ff  <= second_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_in;
      end
   end

   // Threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff      <= DEBOUNCE_RESET;
         long_press_ff    <= LONG_PRESS_RESET;
         double_window_ff <= DOUBLE_WINDOW_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DEBOUNCE:      debounce_ff      <= csr_wdata[THRESH_WIDTH-1:0];
            CSR_LONG_PRESS:    long_press_ff    <= csr_wdata[THRESH_WIDTH-1:0];
            CSR_DOUBLE_WINDOW: double_window_ff <= csr_wdata[THRESH_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-2){1'b0}}, kind_ff};

endmodule

// ===== rtl/bcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click classifier checker
// Port-level checks on the request/response handshake and the response word.
// ----------------------------------------------------------------------------
`include "button_click_classifier_unit_macros.svh"

module bcc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [bcc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);
   import bcc_pkg::*;

   // A stalled response word stays put
   `BCC_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response word changed while stalled")

   // Every word taken yields a response on the next cycle
   `BCC_ASSERT_CLK(a_rsp_follows, clock, reset, req_tvalid && req_tready |=> rsp_tvalid, "taken word gave no response")

   // An empty response register never blocks the request side
   `BCC_ASSERT_CLK(a_ready_free, clock, reset, !rsp_tvalid |-> req_tready, "request blocked with empty response register")

   // Reset empties the response register
   `BCC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "response valid after reset")

   // Padding bits of the response word stay zero
   `BCC_ASSERT_CLK(a_rsp_pad, clock, reset, rsp_tvalid |-> rsp_tdata[RSP_DATA_WIDTH-1:2] == '0, "response padding not zero")

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
